[rtl/core/cfbs_pkg.sv]
// Shared types, register indexes, pipeline layout and CORDIC angle table.
package cfbs_pkg;

   typedef enum logic [2:0] {
      REG_MODE     = 3'd0,
      REG_SOURCE_X = 3'd1,
      REG_SOURCE_Y = 3'd2,
      REG_WIDTH    = 3'd3,
      REG_HEIGHT   = 3'd4
   } reg_index_type;

   typedef enum logic [2:0] {
      MODE_NORTH = 3'd0,
      MODE_EAST  = 3'd1,
      MODE_LIGHT = 3'd2,
      MODE_RAD   = 3'd3,
      MODE_TEMP  = 3'd4
   } mode_type;

   localparam int CORDIC_STEPS = 16;
   localparam int DIV_STEPS    = 30;
   localparam int SQRT_STEPS   = 15;
   localparam int ST_CORDIC0   = 2;
   localparam int ST_DIV0      = 3;
   localparam int ST_SQRT0     = ST_DIV0 + DIV_STEPS;
   localparam int NUM_STAGES   = ST_SQRT0 + SQRT_STEPS;

   localparam logic signed [15:0] Q_ONE       = 16'sd16384;
   localparam logic signed [15:0] LIGHT_FLOOR = 16'sd8192;
   localparam logic signed [15:0] RAD_MAX     = -16'sd3277;
   localparam logic signed [15:0] TEMP_FLOOR  = -16'sd4915;
   localparam logic signed [15:0] TEMP_LIMIT  = 16'sd4096;
   localparam logic signed [21:0] BASE_EAST   = 22'sd368640;
   localparam logic signed [21:0] BASE_WEST   = 22'sd1105920;
   localparam logic        [8:0]  BEARING_MAX = 9'd360;

   typedef struct packed {
      logic [2:0]         mode;
      logic               half_surv;
      logic signed [10:0] vx;
      logic signed [10:0] vy;
      logic               east;
      logic               by_zero;
      logic signed [29:0] cx;
      logic signed [29:0] cy;
      logic signed [19:0] cz;
      logic [21:0]        dsq;
      logic [23:0]        diag;
      logic               sat;
      logic [24:0]        rem;
      logic [29:0]        quo;
      logic [29:0]        rad;
      logic [30:0]        root;
   } pipe_type;

   function automatic logic [17:0] atan_lut(input int i);
      logic [17:0] v;
      case (i)
         0: v = 18'd184317;
         1: v = 18'd108809;
         2: v = 18'd57492;
         3: v = 18'd29184;
         4: v = 18'd14648;
         5: v = 18'd7331;
         6: v = 18'd3667;
         7: v = 18'd1833;
         8: v = 18'd917;
         9: v = 18'd458;
         10: v = 18'd229;
         11: v = 18'd115;
         12: v = 18'd57;
         13: v = 18'd29;
         14: v = 18'd14;
         15: v = 18'd7;
         default: v = 18'd0;
      endcase
      return v;
   endfunction

endpackage

[rtl/core/cell_field_bearing_selector_core.sv]
// Grid cell evaluator: half selection or source field bearing, proximity and survive.
//
// Input channel req_*: one transaction per cell, tdata = {cell_y, cell_x}.
// Result channel rsp_*: one transaction per cell in input order; tdata holds
// bearing_deg, proximity and survive, tuser holds field_written.
// Registers are written through csr_we/csr_addr/csr_wdata: 0 mode, 1 source_x,
// 2 source_y, 3 grid_width, 4 grid_height. The user must write them only while no
// cell is in flight; the block does not enforce this. From the input transaction
// to result valid a cell passes stage 0 (offsets, loaded at the accepting edge),
// then squares and CORDIC seed, divider seed, 30 restoring divide stages (one
// quotient bit each) and 15 square root stages, then the result register. The 16
// CORDIC iterations run beside the divider seed and the first divide stages.
// Throughput is one cell per cycle while no result stalls. A stalled result
// register freezes the whole pipeline; req_tready drops only while a result
// waits and the receiver holds rsp_tready low, so nothing is lost or repeated.
// Synchronous reset empties the pipeline and restores register defaults
// (mode 0, source 0,0, grid GRID_MAX by GRID_MAX).
module cell_field_bearing_selector_core #(
   parameter int GRID_MAX = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [9:0] cell_x, [19:10] cell_y
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [8:0] bearing_deg, [24:9] proximity, [25] survive
   output logic        rsp_tuser,   // [0] field_written
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [10:0] csr_wdata
);
   import cfbs_pkg::*;

   localparam logic [10:0] GRID_RESET = 11'(GRID_MAX);

   logic [2:0]  mode_ff;
   logic [9:0]  src_x_ff;
   logic [9:0]  src_y_ff;
   logic [10:0] grid_w_ff;
   logic [10:0] grid_h_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_NORTH;
         src_x_ff  <= '0;
         src_y_ff  <= '0;
         grid_w_ff <= GRID_RESET;
         grid_h_ff <= GRID_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_MODE:     mode_ff   <= csr_wdata[2:0];
            REG_SOURCE_X: src_x_ff  <= csr_wdata[9:0];
            REG_SOURCE_Y: src_y_ff  <= csr_wdata[9:0];
            REG_WIDTH:    grid_w_ff <= csr_wdata;
            REG_HEIGHT:   grid_h_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic     pipe_en;
   logic     rsp_valid_ff;
   pipe_type st_ff  [NUM_STAGES];
   pipe_type st_in  [NUM_STAGES];
   logic     vld_ff [NUM_STAGES];

   assign pipe_en    = !rsp_valid_ff || rsp_tready;
   assign req_tready = pipe_en;

   // stage 0: offsets and half-grid tests
   always_comb begin
      logic [9:0] cx;
      logic [9:0] cy;
      cx = req_tdata[9:0];
      cy = req_tdata[19:10];
      st_in[0] = '0;
      st_in[0].mode = mode_ff;
      st_in[0].vx = $signed({1'b0, src_x_ff}) - $signed({1'b0, cx});
      st_in[0].vy = $signed({1'b0, src_y_ff}) - $signed({1'b0, cy});
      case (mode_ff)
         MODE_NORTH: st_in[0].half_surv = ({1'b0, cx} < grid_w_ff) &&
                                          ({1'b0, cy} < (grid_h_ff >> 1));
         MODE_EAST:  st_in[0].half_surv = ({1'b0, cx} >= (grid_w_ff >> 1)) &&
                                          ({1'b0, cx} < grid_w_ff) &&
                                          ({1'b0, cy} < grid_h_ff);
         default:    st_in[0].half_surv = 1'b0;
      endcase
   end

   for (genvar s = 1; s < NUM_STAGES; s++) begin : g_stage
      always_comb begin
         logic signed [21:0] px;
         logic signed [21:0] py;
         logic signed [10:0] ax;
         logic signed [10:0] bx;
         logic signed [10:0] by;
         logic signed [29:0] ox;
         logic signed [29:0] oy;
         logic [24:0]        r2;
         logic [30:0]        trial;
         logic [30:0]        bit_w;
         px = '0;
         py = '0;
         ax = '0;
         bx = '0;
         by = '0;
         ox = '0;
         oy = '0;
         r2 = '0;
         trial = '0;
         bit_w = '0;
         st_in[s] = st_ff[s-1];
         if (s == 1) begin
            px = st_ff[0].vx * st_ff[0].vx;
            py = st_ff[0].vy * st_ff[0].vy;
            st_in[s].dsq = 22'(px) + 22'(py);
            st_in[s].diag = 24'(grid_w_ff) * 24'(grid_w_ff) +
                            24'(grid_h_ff) * 24'(grid_h_ff);
            ax = (st_ff[0].vx == 11'sd0) ? 11'sd1 : st_ff[0].vx;
            st_in[s].east = !ax[10];
            bx = ax[10] ? -ax : ax;
            by = ax[10] ? -st_ff[0].vy : st_ff[0].vy;
            st_in[s].by_zero = (by == 11'sd0);
            st_in[s].cx = 30'(bx) <<< 16;
            st_in[s].cy = 30'(by) <<< 16;
            st_in[s].cz = '0;
         end
         if (s == ST_CORDIC0) begin
            st_in[s].sat = {st_ff[s-1].dsq, 2'b00} >= st_ff[s-1].diag;
            st_in[s].rem = {1'b0, st_ff[s-1].dsq, 2'b00};
            st_in[s].quo = '0;
         end
         if (s >= ST_CORDIC0 && s < ST_CORDIC0 + CORDIC_STEPS) begin
            ox = st_ff[s-1].cx;
            oy = st_ff[s-1].cy;
            if (!oy[29]) begin
               st_in[s].cx = ox + (oy >>> (s - ST_CORDIC0));
               st_in[s].cy = oy - (ox >>> (s - ST_CORDIC0));
               st_in[s].cz = st_ff[s-1].cz + $signed({2'b00, atan_lut(s - ST_CORDIC0)});
            end else begin
               st_in[s].cx = ox - (oy >>> (s - ST_CORDIC0));
               st_in[s].cy = oy + (ox >>> (s - ST_CORDIC0));
               st_in[s].cz = st_ff[s-1].cz - $signed({2'b00, atan_lut(s - ST_CORDIC0)});
            end
         end
         if (s >= ST_DIV0 && s < ST_SQRT0) begin
            r2 = {st_ff[s-1].rem[23:0], 1'b0};
            if (r2 >= {1'b0, st_ff[s-1].diag}) begin
               st_in[s].rem = r2 - {1'b0, st_ff[s-1].diag};
               st_in[s].quo = {st_ff[s-1].quo[28:0], 1'b1};
            end else begin
               st_in[s].rem = r2;
               st_in[s].quo = {st_ff[s-1].quo[28:0], 1'b0};
            end
         end
         if (s >= ST_SQRT0) begin
            if (s == ST_SQRT0) begin
               st_in[s].rad  = st_ff[s-1].quo;
               st_in[s].root = '0;
            end
            bit_w = 31'(1) << (2 * (NUM_STAGES - 1 - s));
            trial = st_in[s].root + bit_w;
            if ({1'b0, st_in[s].rad} >= trial) begin
               st_in[s].rad  = 30'({1'b0, st_in[s].rad} - trial);
               st_in[s].root = (st_in[s].root >> 1) + bit_w;
            end else begin
               st_in[s].root = st_in[s].root >> 1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         for (int s = 0; s < NUM_STAGES; s++) begin
            st_ff[s] <= st_in[s];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NUM_STAGES; s++) begin
            vld_ff[s] <= 1'b0;
         end
      end else if (pipe_en) begin
         vld_ff[0] <= req_tvalid;
         for (int s = 1; s < NUM_STAGES; s++) begin
            vld_ff[s] <= vld_ff[s-1];
         end
      end
   end

   // result stage
   pipe_type           fin;
   logic signed [21:0] ang;
   logic [8:0]         bear;
   logic [14:0]        root_e;
   logic signed [15:0] prox;
   logic [8:0]         bearing_in;
   logic signed [15:0] prox_in;
   logic               written_in;
   logic               surv_in;
   logic [8:0]         bearing_ff;
   logic signed [15:0] prox_ff;
   logic               written_ff;
   logic               surv_ff;

   assign fin = st_ff[NUM_STAGES-1];

   always_comb begin
      ang = (fin.east ? BASE_EAST : BASE_WEST) -
            (fin.by_zero ? 22'sd0 : 22'(fin.cz));
      if (ang[21]) begin
         bear = '0;
      end else if (ang[20:12] > BEARING_MAX) begin
         bear = BEARING_MAX;
      end else begin
         bear = ang[20:12];
      end
      root_e = fin.root[14:0];
      prox = fin.sat ? -Q_ONE : (Q_ONE - $signed({1'b0, root_e}));
      bearing_in = '0;
      prox_in    = '0;
      written_in = 1'b0;
      surv_in    = 1'b0;
      case (fin.mode) inside
         MODE_NORTH, MODE_EAST: surv_in = fin.half_surv;
         MODE_LIGHT, MODE_RAD, MODE_TEMP: begin
            bearing_in = bear;
            prox_in    = prox;
            written_in = 1'b1;
            if (fin.mode == MODE_LIGHT) begin
               surv_in = prox >= LIGHT_FLOOR;
            end else if (fin.mode == MODE_RAD) begin
               surv_in = prox <= RAD_MAX;
            end else begin
               surv_in = (prox >= TEMP_FLOOR) && (prox < TEMP_LIMIT);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         rsp_valid_ff <= vld_ff[NUM_STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         bearing_ff <= bearing_in;
         prox_ff    <= prox_in;
         written_ff <= written_in;
         surv_ff    <= surv_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, surv_ff, prox_ff, bearing_ff};
   assign rsp_tuser  = written_ff;

   a_ready_follows_stall : assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_valid_ff || rsp_tready))
      else $error("input ready disagrees with result stall");

   a_reset_empties : assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   a_bearing_range : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[8:0] <= BEARING_MAX)
      else $error("bearing out of range");

   a_half_fields_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[24:0] == 25'd0)
      else $error("field values present without field mode");

endmodule

[tb/cell_field_bearing_selector_core_tb.sv]
// Self-checking testbench for the grid cell field, bearing and selector core.
module cell_field_bearing_selector_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import cfbs_pkg::*;

   typedef struct {
      logic [8:0]         bearing;
      logic signed [15:0] prox;
      logic               written;
      logic               surv;
   } cell_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_addr = '0;
   logic [10:0] csr_wdata = '0;

   logic [19:0]     cell_q[$];
   cell_result_type result_q[$];
   int errors = 0;
   int cells_sent = 0;
   int results_seen = 0;
   int phases_run = 0;
   int hold_cnt = 0;
   bit hold_done = 0;

   logic [2:0]  cur_mode = 3'd0;
   logic [9:0]  cur_sx = '0, cur_sy = '0;
   logic [10:0] cur_w = 11'd1024, cur_h = 11'd1024;

   longint atan_steps[16] = '{184317, 108809, 57492, 29184, 14648, 7331, 3667, 1833,
                              917, 458, 229, 115, 57, 29, 14, 7};

   cell_field_bearing_selector_core u_top (.*);

   always #5 clock = ~clock;

   function automatic longint cordic_angle(longint bx, longint by);
      longint x, y, z, dx, dy;
      x = bx * 65536;
      y = by * 65536;
      z = 0;
      if (by == 0) return 0;
      for (int i = 0; i < 16; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y >= 0) begin
            x += dx; y -= dy; z += atan_steps[i];
         end else begin
            x -= dx; y += dy; z -= atan_steps[i];
         end
      end
      return z;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned n);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= res + b) begin
            n -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   function automatic cell_result_type predict_cell(logic [9:0] cx, logic [9:0] cy);
      cell_result_type r;
      longint vx, vy, ax, bx, by, base, val, e;
      longint unsigned d, g;
      r = '{9'd0, 16'sd0, 1'b0, 1'b0};
      case (cur_mode) inside
         MODE_NORTH: r.surv = (cx < cur_w) && (cy < cur_h / 2);
         MODE_EAST:  r.surv = (cx >= cur_w / 2) && (cx < cur_w) && (cy < cur_h);
         MODE_LIGHT, MODE_RAD, MODE_TEMP: begin
            vx = longint'(cur_sx) - longint'(cx);
            vy = longint'(cur_sy) - longint'(cy);
            ax = (vx == 0) ? 1 : vx;
            base = (ax > 0) ? 90 : 270;
            bx = (ax > 0) ? ax : -ax;
            by = (ax > 0) ? vy : -vy;
            val = base * 4096 - cordic_angle(bx, by);
            if (val < 0) val = 0;
            val = val / 4096;
            if (val > 360) val = 360;
            r.bearing = val[8:0];
            d = vx * vx + vy * vy;
            g = longint'(cur_w) * cur_w + longint'(cur_h) * cur_h;
            if (g == 0) e = 32768;
            else begin
               e = int_sqrt((d << 32) / g);
               if (e > 32768) e = 32768;
            end
            r.prox = 16'(16384 - e);
            r.written = 1'b1;
            if (cur_mode == MODE_LIGHT) r.surv = r.prox >= LIGHT_FLOOR;
            else if (cur_mode == MODE_RAD) r.surv = r.prox <= RAD_MAX;
            else r.surv = (r.prox >= TEMP_FLOOR) && (r.prox < TEMP_LIMIT);
         end
         default: ;
      endcase
      return r;
   endfunction

   // driver
   always @(posedge clock) begin
      int idle_pct;
      logic [19:0] c;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            c = cell_q.pop_front();
            result_q.push_back(predict_cell(c[9:0], c[19:10]));
            cells_sent++;
         end
         idle_pct = (cells_sent < 200) ? 31 : (cells_sent < 400) ? 83 : 0;
         if (req_tvalid && !req_tready) begin
            // hold current transaction
         end else if (cell_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
            req_tvalid <= 1'b1;
            req_tdata  <= {4'd0, cell_q[0]};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      int idle_pct;
      cell_result_type x;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (result_q.size() == 0) begin
               errors++;
               $display("%0t: unexpected result tdata=%h tuser=%b", $time, rsp_tdata, rsp_tuser);
            end else begin
               x = result_q.pop_front();
               if (rsp_tdata[8:0] !== x.bearing) begin
                  errors++;
                  $display("%0t: bearing exp %0d got %0d", $time, x.bearing, rsp_tdata[8:0]);
               end
               if ($signed(rsp_tdata[24:9]) !== x.prox) begin
                  errors++;
                  $display("%0t: proximity exp %0d got %0d", $time, x.prox,
                           $signed(rsp_tdata[24:9]));
               end
               if (rsp_tdata[25] !== x.surv) begin
                  errors++;
                  $display("%0t: survive exp %b got %b", $time, x.surv, rsp_tdata[25]);
               end
               if (rsp_tuser !== x.written) begin
                  errors++;
                  $display("%0t: field_written exp %b got %b", $time, x.written, rsp_tuser);
               end
            end
         end
         // long back-pressure stretch once
         if (!hold_done && results_seen == 100 && hold_cnt == 0) hold_cnt = 300;
         idle_pct = (cells_sent < 200) ? 83 : (cells_sent < 400) ? 31 : 0;
         if (hold_cnt > 0) begin
            hold_cnt--;
            if (hold_cnt == 0) hold_done = 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= idle_pct);
         end
      end
   end

   task automatic wait_idle();
      while (cell_q.size() != 0 || req_tvalid || result_q.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_config(logic [2:0] m, logic [9:0] sx, logic [9:0] sy,
                               logic [10:0] w, logic [10:0] h);
      wait_idle();
      @(posedge clock);
      csr_we <= 1'b1; csr_addr <= REG_MODE; csr_wdata <= {8'd0, m};
      @(posedge clock);
      csr_addr <= REG_SOURCE_X; csr_wdata <= {1'b0, sx};
      @(posedge clock);
      csr_addr <= REG_SOURCE_Y; csr_wdata <= {1'b0, sy};
      @(posedge clock);
      csr_addr <= REG_WIDTH; csr_wdata <= w;
      @(posedge clock);
      csr_addr <= REG_HEIGHT; csr_wdata <= h;
      @(posedge clock);
      csr_we <= 1'b0;
      cur_mode = m; cur_sx = sx; cur_sy = sy; cur_w = w; cur_h = h;
      phases_run++;
   endtask

   task automatic push_cell(logic [9:0] x, logic [9:0] y);
      cell_q.push_back({y, x});
   endtask

   initial begin
      logic [10:0] w, h;
      logic [2:0] m;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      // reset defaults, north half
      push_cell(0, 0); push_cell(1023, 511); push_cell(1023, 512); push_cell(5, 1023);
      write_config(MODE_EAST, 0, 0, 1024, 1024);
      push_cell(511, 3); push_cell(512, 3); push_cell(1023, 1023);
      write_config(MODE_NORTH, 0, 0, 100, 60);
      push_cell(99, 29); push_cell(100, 29); push_cell(50, 30);
      write_config(MODE_LIGHT, 500, 500, 1024, 1024);
      push_cell(500, 500); push_cell(500, 0); push_cell(500, 1023); push_cell(0, 500);
      push_cell(1023, 500); push_cell(600, 400);
      write_config(MODE_RAD, 1023, 1023, 1, 1);
      push_cell(0, 0); push_cell(1023, 0); push_cell(1023, 1023);
      write_config(MODE_TEMP, 0, 1023, 0, 0);
      push_cell(0, 0); push_cell(10, 20);
      write_config(3'd7, 1023, 0, 2047, 2047);
      push_cell(1023, 1023); push_cell(0, 0);

      for (int p = 0; p < 10; p++) begin
         m = ($urandom_range(9) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
         w = ($urandom_range(9) == 0) ? 11'($urandom) : 11'($urandom_range(1, 1024));
         h = ($urandom_range(9) == 0) ? 11'($urandom) : 11'($urandom_range(1, 1024));
         write_config(m, 10'($urandom), 10'($urandom), w, h);
         for (int i = 0; i < 60; i++) begin
            if ($urandom_range(3) == 0) push_cell(10'($urandom), 10'($urandom));
            else push_cell(10'($urandom_range(0, (w > 0 && w <= 1024) ? w - 1 : 1023)),
                           10'($urandom_range(0, (h > 0 && h <= 1024) ? h - 1 : 1023)));
         end
      end
      wait_idle();
      $display("Covered %0d cells over %0d register settings, all modes and grid extremes.",
               cells_sent, phases_run);
      $display("Checked %0d results with random idling and one long receiver stall.",
               results_seen);
      if (errors == 0 && result_q.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("Test completed with failures");
      $finish;
   end
endmodule

[sim.f]
rtl/core/cfbs_pkg.sv
rtl/core/cell_field_bearing_selector_core.sv
tb/cell_field_bearing_selector_core_tb.sv
